// ----- hdl/rri_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the ray/rectangle intersection pipeline.
// No dependencies; every other file in hdl/ imports this package.
package rri_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int COORD_W       = 32;
	localparam int THR_W         = 16;

	// Quotient magnitude bits kept by the divider; anything larger saturates.
	localparam int QMAG_W = 31;

	// floor(x / 100000) for x < 2^31: (x * RECIP_M) >> RECIP_SHIFT, then one fixup.
	localparam int                RECIP_SHIFT = 47;
	localparam logic [QMAG_W-1:0] RECIP_M     = 31'd1407374883;
	localparam logic [16:0]       SCALE_DIV   = 17'd100000;
	localparam int                EST_W       = 2 * QMAG_W - RECIP_SHIFT;

	localparam logic [COORD_W-1:0] DIST_MAX = 32'h7FFF_FFFF;
	localparam logic [COORD_W-1:0] DIST_MIN = 32'h8000_0000;

	typedef enum logic [2:0] {
		REG_CORNER_X = 3'd0,
		REG_CORNER_Y = 3'd1,
		REG_CORNER_Z = 3'd2,
		REG_SPAN_X   = 3'd3,
		REG_SPAN_Y   = 3'd4,
		REG_THRESH   = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] corner_x;
		logic signed [COORD_W-1:0] corner_y;
		logic signed [COORD_W-1:0] corner_z;
		logic signed [COORD_W-1:0] span_x;
		logic signed [COORD_W-1:0] span_y;
		logic        [THR_W-1:0]   threshold;
	} cfg_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] origin_x;
		logic signed [COORD_W-1:0] origin_y;
		logic signed [COORD_W-1:0] origin_z;
		logic signed [COORD_W-1:0] dir_x;
		logic signed [COORD_W-1:0] dir_y;
		logic signed [COORD_W-1:0] dir_z;
	} ray_t;

	// Per-word control that travels with the divider and scaler stages.
	typedef struct packed {
		logic valid;
		logic hit;
		logic qneg;
		logic sat;
	} pipe_ctl_t;

	typedef struct packed {
		logic                      hit;
		logic signed [COORD_W-1:0] distance;
	} res_t;

endpackage

// ----- hdl/rri_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces for ray words and result words.
// Field widths come from rri_pkg.
interface rri_ray_if;
	import rri_pkg::*;
	logic                      valid;
	logic                      ready;
	logic signed [COORD_W-1:0] origin_x;
	logic signed [COORD_W-1:0] origin_y;
	logic signed [COORD_W-1:0] origin_z;
	logic signed [COORD_W-1:0] dir_x;
	logic signed [COORD_W-1:0] dir_y;
	logic signed [COORD_W-1:0] dir_z;
	modport source (output valid, output origin_x, output origin_y, output origin_z,
		output dir_x, output dir_y, output dir_z, input ready);
	modport sink (input valid, input origin_x, input origin_y, input origin_z,
		input dir_x, input dir_y, input dir_z, output ready);
endinterface

interface rri_res_if;
	import rri_pkg::*;
	logic                      valid;
	logic                      ready;
	logic                      hit;
	logic signed [COORD_W-1:0] distance;
	modport source (output valid, output hit, output distance, input ready);
	modport sink (input valid, input hit, input distance, output ready);
endinterface

// ----- hdl/ray_rectangle_intersect.sv -----
`timescale 1ns / 1ps
// Top level of the ray versus axis-aligned rectangle intersection unit.
// Uses rri_pkg, rri_if, rri_geom, rri_div and rri_scale.

// Accepts one ray word per clock while the output buffer has room, and
// returns one result word per ray, in order. The stages are the range
// checks and exact cross-multiplied bounds tests, a pipelined restoring
// divider (one quotient bit per stage), the 1.00001 scaling and saturation,
// and the output buffer. A two-word output buffer sits between the pipeline
// and the result channel, so ray ready depends only on buffer fill and never
// on result ready; when the buffer is full the whole pipeline holds. Registers
// are written through cfg_we/cfg_index/cfg_wdata (indexes 0..5: corner_x,
// corner_y, corner_z, span_x, span_y, parallel_threshold; other indexes are
// dropped) and should only change while no ray is in flight. All coordinates
// are signed fixed point with FRAC_BITS fraction bits. A miss returns hit 0
// and distance 0.
module ray_rectangle_intersect import rri_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [COORD_W-1:0] cfg_wdata,
	rri_ray_if.sink            ray,
	rri_res_if.source          result
);

	localparam int OUT_DEPTH = 2;

	cfg_t      cfg_q;
	ray_t      ray_word;
	logic      en;
	pipe_ctl_t geom_ctl;
	logic [FRAC_BITS-1:0] geom_mag, geom_rem;
	logic [QMAG_W-1:0]    geom_low;
	pipe_ctl_t            div_ctl;
	logic [QMAG_W-1:0]    div_quo;
	logic                 scl_valid;
	res_t                 scl_res;

	// output buffer
	res_t       buf_q [OUT_DEPTH];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	logic       push, pop;

	// register file; reset gives a unit square at the origin plane
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.corner_x  <= '0;
			cfg_q.corner_y  <= '0;
			cfg_q.corner_z  <= '0;
			cfg_q.span_x    <= COORD_W'(1) << FRAC_BITS;
			cfg_q.span_y    <= COORD_W'(1) << FRAC_BITS;
			cfg_q.threshold <= '0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_CORNER_X: cfg_q.corner_x  <= cfg_wdata;
				REG_CORNER_Y: cfg_q.corner_y  <= cfg_wdata;
				REG_CORNER_Z: cfg_q.corner_z  <= cfg_wdata;
				REG_SPAN_X:   cfg_q.span_x    <= cfg_wdata;
				REG_SPAN_Y:   cfg_q.span_y    <= cfg_wdata;
				REG_THRESH:   cfg_q.threshold <= cfg_wdata[THR_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// advance every stage together unless the output buffer is full
	assign en        = (count_q != 2'(OUT_DEPTH));
	assign ray.ready = en;

	assign ray_word = '{origin_x: ray.origin_x, origin_y: ray.origin_y,
		origin_z: ray.origin_z, dir_x: ray.dir_x, dir_y: ray.dir_y, dir_z: ray.dir_z};

	rri_geom #(.FRAC_BITS(FRAC_BITS)) u_geom (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (ray.valid),
		.ray      (ray_word),
		.cfg      (cfg_q),
		.ctl      (geom_ctl),
		.mag      (geom_mag),
		.rem      (geom_rem),
		.low      (geom_low)
	);

	rri_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.ctl_in (geom_ctl),
		.mag_in (geom_mag),
		.rem_in (geom_rem),
		.low_in (geom_low),
		.ctl    (div_ctl),
		.quo    (div_quo)
	);

	rri_scale u_scale (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.ctl_in (div_ctl),
		.quo_in (div_quo),
		.valid  (scl_valid),
		.res    (scl_res)
	);

	// the last stage's word moves into the buffer on the edge that advances it
	assign push = en && scl_valid;
	assign pop  = result.valid && result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= scl_res;
		end
	end

	assign result.valid    = (count_q != '0);
	assign result.hit      = buf_q[rd_ptr_q].hit;
	assign result.distance = buf_q[rd_ptr_q].distance;

endmodule

// ----- hdl/rri_geom.sv -----
`timescale 1ns / 1ps
// Front end: range checks, exact cross-multiplied hit test and divider setup.
// Four register stages; depends on rri_pkg.
module rri_geom import rri_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  ray_t                 ray,
	input  cfg_t                 cfg,
	output pipe_ctl_t            ctl,
	output logic [FRAC_BITS-1:0] mag,
	output logic [FRAC_BITS-1:0] rem,
	output logic [QMAG_W-1:0]    low
);

	localparam int MW = FRAC_BITS;
	localparam int EW = COORD_W + 1;
	localparam int XW = 2 * COORD_W + 1;
	localparam int PW = 2 * COORD_W + 2;
	localparam int DW = COORD_W + FRAC_BITS;
	localparam logic [COORD_W-1:0] ONE = COORD_W'(1) << FRAC_BITS;

	// stage 1
	logic [COORD_W-1:0] dz_mag;
	logic               dir_ok;
	logic               span_ok;

	logic                      v_s1, ok_s1, dneg_s1;
	logic signed [EW-1:0]      num_s1, dax_s1, lim_x_s1, day_s1, lim_y_s1;
	logic signed [COORD_W-1:0] ox_s1, oy_s1, dx_s1, dy_s1;
	logic        [MW-1:0]      mag_s1;

	// stage 2
	logic                      v_s2, ok_s2, dneg_s2, qneg_s2;
	logic signed [EW-1:0]      dax_s2, day_s2;
	logic signed [EW:0]        dbx_s2, dby_s2;
	logic signed [XW-1:0]      px_s2, py_s2;
	logic        [COORD_W-1:0] anum_s2;
	logic        [MW-1:0]      mag_s2;

	// stage 3
	logic signed [MW:0]   dmul;
	logic        [DW-1:0] dvd;
	logic        [MW:0]   rem0;

	logic                     v_s3, ok_s3, qneg_s3, sat_s3;
	logic signed [PW-1:0]     pax_s3, pbx_s3, ppx_s3, pay_s3, pby_s3, ppy_s3;
	logic        [MW-1:0]     mag_s3, rem_s3;
	logic        [QMAG_W-1:0] low_s3;

	// stage 4
	logic in_x, in_y;

	pipe_ctl_t            ctl_s4;
	logic [MW-1:0]        mag_s4, rem_s4;
	logic [QMAG_W-1:0]    low_s4;

	assign dz_mag  = ray.dir_z[COORD_W-1] ? (~ray.dir_z + 1'b1) : ray.dir_z;
	assign dir_ok  = (dz_mag > COORD_W'(cfg.threshold)) && (dz_mag < ONE);
	assign span_ok = (cfg.span_x != '0) && (cfg.span_y != '0);

	assign dmul = {1'b0, mag_s2};
	assign dvd  = {anum_s2, {MW{1'b0}}};
	assign rem0 = dvd[DW-1:QMAG_W];

	// lo <= p <= hi, with the interval ends in either order
	assign in_x = ((pax_s3 <= ppx_s3) && (ppx_s3 <= pbx_s3)) ||
		((pbx_s3 <= ppx_s3) && (ppx_s3 <= pax_s3));
	assign in_y = ((pay_s3 <= ppy_s3) && (ppy_s3 <= pby_s3)) ||
		((pby_s3 <= ppy_s3) && (ppy_s3 <= pay_s3));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			ctl_s4 <= '0;
		end else if (en) begin
			v_s1   <= in_valid;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			ctl_s4 <= '{valid: v_s3, hit: ok_s3 && in_x && in_y, qneg: qneg_s3, sat: sat_s3};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ok_s1    <= dir_ok && span_ok;
			dneg_s1  <= ray.dir_z[COORD_W-1];
			mag_s1   <= dz_mag[MW-1:0];
			num_s1   <= EW'($signed(cfg.corner_z)) - EW'($signed(ray.origin_z));
			dax_s1   <= EW'($signed(cfg.corner_x)) - EW'($signed(ray.origin_x));
			lim_x_s1 <= EW'($signed(cfg.corner_x)) + EW'($signed(cfg.span_x));
			day_s1   <= EW'($signed(cfg.corner_y)) - EW'($signed(ray.origin_y));
			lim_y_s1 <= EW'($signed(cfg.corner_y)) + EW'($signed(cfg.span_y));
			ox_s1    <= ray.origin_x;
			oy_s1    <= ray.origin_y;
			dx_s1    <= ray.dir_x;
			dy_s1    <= ray.dir_y;

			ok_s2   <= ok_s1;
			dneg_s2 <= dneg_s1;
			mag_s2  <= mag_s1;
			qneg_s2 <= num_s1[EW-1] ^ dneg_s1;
			anum_s2 <= num_s1[EW-1] ? COORD_W'(-num_s1) : COORD_W'(num_s1);
			dax_s2  <= dax_s1;
			day_s2  <= day_s1;
			dbx_s2  <= (EW+1)'(lim_x_s1) - (EW+1)'(ox_s1);
			dby_s2  <= (EW+1)'(lim_y_s1) - (EW+1)'(oy_s1);
			px_s2   <= XW'(dx_s1) * XW'(num_s1);
			py_s2   <= XW'(dy_s1) * XW'(num_s1);

			ok_s3   <= ok_s2;
			qneg_s3 <= qneg_s2;
			mag_s3  <= mag_s2;
			sat_s3  <= rem0 >= {1'b0, mag_s2};
			rem_s3  <= rem0[MW-1:0];
			low_s3  <= dvd[QMAG_W-1:0];
			pax_s3  <= PW'(dax_s2) * PW'(dmul);
			pbx_s3  <= PW'(dbx_s2) * PW'(dmul);
			pay_s3  <= PW'(day_s2) * PW'(dmul);
			pby_s3  <= PW'(dby_s2) * PW'(dmul);
			ppx_s3  <= dneg_s2 ? -PW'(px_s2) : PW'(px_s2);
			ppy_s3  <= dneg_s2 ? -PW'(py_s2) : PW'(py_s2);

			mag_s4 <= mag_s3;
			rem_s4 <= rem_s3;
			low_s4 <= low_s3;
		end
	end

	assign ctl = ctl_s4;
	assign mag = mag_s4;
	assign rem = rem_s4;
	assign low = low_s4;

endmodule

// ----- hdl/rri_div.sv -----
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage, QMAG_W stages.
// Depends on rri_pkg.
module rri_div import rri_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  pipe_ctl_t            ctl_in,
	input  logic [FRAC_BITS-1:0] mag_in,
	input  logic [FRAC_BITS-1:0] rem_in,
	input  logic [QMAG_W-1:0]    low_in,
	output pipe_ctl_t            ctl,
	output logic [QMAG_W-1:0]    quo
);

	localparam int MW = FRAC_BITS;

	pipe_ctl_t         ctl_s [QMAG_W];
	logic [MW-1:0]     mag_s [QMAG_W];
	logic [MW-1:0]     rem_s [QMAG_W];
	logic [QMAG_W-1:0] low_s [QMAG_W];
	logic [QMAG_W-1:0] quo_s [QMAG_W];

	pipe_ctl_t         p_ctl [QMAG_W];
	logic [MW-1:0]     p_mag [QMAG_W];
	logic [MW-1:0]     p_rem [QMAG_W];
	logic [QMAG_W-1:0] p_low [QMAG_W];
	logic [QMAG_W-1:0] p_quo [QMAG_W];
	logic [MW:0]       trial [QMAG_W];
	logic [MW:0]       diff  [QMAG_W];
	logic              take  [QMAG_W];

	// each stage reads only the register of the stage before it
	always_comb begin
		for (int k = 0; k < QMAG_W; k++) begin
			if (k == 0) begin
				p_ctl[k] = ctl_in;
				p_mag[k] = mag_in;
				p_rem[k] = rem_in;
				p_low[k] = low_in;
				p_quo[k] = '0;
			end else begin
				p_ctl[k] = ctl_s[k-1];
				p_mag[k] = mag_s[k-1];
				p_rem[k] = rem_s[k-1];
				p_low[k] = low_s[k-1];
				p_quo[k] = quo_s[k-1];
			end
			trial[k] = {p_rem[k], p_low[k][QMAG_W-1]};
			diff[k]  = trial[k] - {1'b0, p_mag[k]};
			take[k]  = trial[k] >= {1'b0, p_mag[k]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < QMAG_W; k++) begin
				ctl_s[k] <= '0;
			end
		end else if (en) begin
			for (int k = 0; k < QMAG_W; k++) begin
				ctl_s[k] <= p_ctl[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < QMAG_W; k++) begin
				mag_s[k] <= p_mag[k];
				rem_s[k] <= take[k] ? diff[k][MW-1:0] : trial[k][MW-1:0];
				low_s[k] <= p_low[k] << 1;
				quo_s[k] <= {p_quo[k][QMAG_W-2:0], take[k]};
			end
		end
	end

	assign ctl = ctl_s[QMAG_W-1];
	assign quo = quo_s[QMAG_W-1];

endmodule

// ----- hdl/rri_scale.sv -----
`timescale 1ns / 1ps
// Output scaler: t * 1.00001 by reciprocal multiply, sign and saturation.
// Four register stages; depends on rri_pkg.
module rri_scale import rri_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  pipe_ctl_t         ctl_in,
	input  logic [QMAG_W-1:0] quo_in,
	output logic              valid,
	output res_t              res
);

	localparam int PRW = 2 * QMAG_W;

	pipe_ctl_t          ctl_s1, ctl_s2, ctl_s3;
	logic [QMAG_W-1:0]  quo_s1, quo_s2, quo_s3;
	logic [PRW-1:0]     prod_s1;
	logic [EST_W-1:0]   est_s2, cq_s3;
	logic [COORD_W-1:0] back_s2;
	logic [COORD_W-1:0] resid;
	logic [COORD_W-1:0] sum;
	logic [COORD_W-1:0] dist_sat;
	logic               valid_s4;
	res_t               res_s4;

	assign resid = COORD_W'(quo_s2) - back_s2;
	assign sum   = COORD_W'(quo_s3) + COORD_W'(cq_s3);

	always_comb begin
		priority if (!ctl_s3.hit) begin
			dist_sat = '0;
		end else if (ctl_s3.sat) begin
			dist_sat = ctl_s3.qneg ? DIST_MIN : DIST_MAX;
		end else if (ctl_s3.qneg) begin
			dist_sat = (sum > DIST_MIN) ? DIST_MIN : (~sum + 1'b1);
		end else begin
			dist_sat = (sum > DIST_MAX) ? DIST_MAX : sum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1   <= '0;
			ctl_s2   <= '0;
			ctl_s3   <= '0;
			valid_s4 <= 1'b0;
		end else if (en) begin
			ctl_s1   <= ctl_in;
			ctl_s2   <= ctl_s1;
			ctl_s3   <= ctl_s2;
			valid_s4 <= ctl_s3.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quo_s1  <= quo_in;
			prod_s1 <= PRW'(quo_in) * PRW'(RECIP_M);
			quo_s2  <= quo_s1;
			est_s2  <= prod_s1[PRW-1:RECIP_SHIFT];
			back_s2 <= COORD_W'(prod_s1[PRW-1:RECIP_SHIFT]) * COORD_W'(SCALE_DIV);
			quo_s3  <= quo_s2;
			// estimate is low by at most one
			cq_s3   <= est_s2 + EST_W'(resid >= COORD_W'(SCALE_DIV));
			res_s4  <= '{hit: ctl_s3.hit, distance: dist_sat};
		end
	end

	assign valid = valid_s4;
	assign res   = res_s4;

endmodule

// ----- hdl/rri_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for ray_rectangle_intersect, attached by bind.
// Depends on rri_pkg and the top level's ports.
module rri_checker import rri_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               ray_ready,
	input logic               res_valid,
	input logic               res_ready,
	input logic               res_hit,
	input logic [COORD_W-1:0] res_distance
);

	// a waiting result word stays offered
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result word dropped while stalled");

	// a miss always reports zero distance
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_hit |-> res_distance == '0)
		else $error("miss with nonzero distance");

	// the input only backs up when results are waiting
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!ray_ready |-> res_valid)
		else $error("input stalled with no result waiting");

	// result ready in the previous cycle leaves the input side free
	a_ready_return: assert property (@(posedge clk) disable iff (!arst_n)
		$past(res_ready) |-> ray_ready)
		else $error("input still stalled after result was drained");

endmodule

bind ray_rectangle_intersect rri_checker u_rri_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.ray_ready    (ray.ready),
	.res_valid    (result.valid),
	.res_ready    (result.ready),
	.res_hit      (result.hit),
	.res_distance (result.distance)
);
